[design/latching_relay_pulse_scheduler_top_assert.svh]
// assertion macros shared by the relay pulse scheduler rtl
// no dependencies; taken in by `include where checks are written
`ifndef LATCHING_RELAY_PULSE_SCHEDULER_TOP_ASSERT_SVH
`define LATCHING_RELAY_PULSE_SCHEDULER_TOP_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define LRPS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lrps invariant failed");

// consequence checked in the same cycle as the trigger
`define LRPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrps check failed");

// consequence checked in the cycle after the trigger
`define LRPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrps sequence check failed");

`endif

[design/lrps_pkg.sv]
// types and constants of the relay pulse scheduler
// no dependencies; imported by lrps_unit, the scheduler top, the checker and the testbench
`default_nettype none

package lrps_pkg;

  localparam int RELAYS     = 3;
  localparam int TIME_BITS  = 32;
  localparam int RELAY_W    = 2;
  localparam int HOLD_W     = 16;
  localparam int COIL_W     = 2 * RELAYS;
  localparam int COIL_IDX_W = $clog2(COIL_W);
  localparam int FREE_W     = 4;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd400;
  localparam int MIN_FREE = 2;

  // shared unit operations
  typedef logic unit_op_t;
  localparam unit_op_t UNIT_OP_ADD = 1'b0;
  localparam unit_op_t UNIT_OP_LT  = 1'b1;

  // input item kinds carried on tuser
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_TOGGLE = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] when;
    logic [RELAY_W-1:0]   relay;
    logic                 set_coil;
    logic                 level;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

[design/lrps_ram.sv]
// generic single write port ram with registered read
// no package dependencies
`default_nettype none

module lrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/lrps_unit.sv]
// shared time adder: wrapping add, or unsigned less-than by subtraction
// depends on lrps_pkg
`default_nettype none

module lrps_unit import lrps_pkg::*; (
  input  wire unit_op_t             op,
  input  wire logic [TIME_BITS-1:0] a,
  input  wire logic [TIME_BITS-1:0] b,
  output      logic [TIME_BITS-1:0] sum,
  output      logic                 lt
);

  logic                 sub;
  logic [TIME_BITS-1:0] b_in;
  logic [TIME_BITS:0]   wide;

  always_comb begin
    sub  = (op == UNIT_OP_LT);
    b_in = sub ? ~b : b;
    wide = {1'b0, a} + {1'b0, b_in} + (TIME_BITS + 1)'(sub);
  end

  assign sum = wide[TIME_BITS-1:0];
  // no carry out of a - b means a borrow, so a < b
  assign lt  = sub & ~wide[TIME_BITS];

endmodule

`default_nettype wire

[design/latching_relay_pulse_scheduler_top.sv]
// Latching relay pulse scheduler. A toggle request (tuser = 1) books a
// raise-coil event at its start time and a drop-coil event hold_ticks later
// into the two lowest free slots of the event table, or is refused when
// fewer than two slots are free. A tick (tuser = 0) fires, in slot order,
// every booked event whose time is strictly below the tick time and frees
// its slot. Every item gives one result: accepted flag, coil drive lines
// and free slot count. One item is worked on at a time; its result waits in
// the output register, so the next input transfer is taken while it waits,
// and that item's report holds until the register is free. With the receiver
// ready a tick's result waits for a scan of the whole table, an accepted
// toggle's for a scan up to its second free slot and a refused toggle's for none;
// the tick scan takes one table entry a cycle through the single read port of
// the slot memory and the one shared time adder.
// The slot contents need no clearing after reset, the block is ready at once.
// depends on lrps_pkg, lrps_ram, lrps_unit and the assertion macro header
`default_nettype none

`include "latching_relay_pulse_scheduler_top_assert.svh"

module latching_relay_pulse_scheduler_top import lrps_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [HOLD_W-1:0]  cfg_wr_data,   // hold_ticks
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [39:0]        s_axis_tdata,  // relay_index, set_coil, time_value
  input  wire logic               s_axis_tuser,  // func
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [15:0]        m_axis_tdata   // accepted, coil_lines, free_slots
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TADD   = 3'd1;
  localparam logic [2:0] ST_TFILL  = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]           state;
  logic [HOLD_W-1:0]    hold_ticks;
  logic [SLOTS-1:0]     busy;
  logic [CNT_W-1:0]     free_cnt;
  logic [COIL_W-1:0]    coil_drive;
  logic                 acc;
  logic                 out_free;

  logic [RELAY_W-1:0]   item_relay;
  logic                 item_set;
  logic [TIME_BITS-1:0] item_time;
  logic [TIME_BITS-1:0] t_end;

  logic [IDX_W-1:0]     scan_idx;
  logic                 scan_done;
  logic [IDX_W-1:0]     eval_idx;
  logic                 eval_vld;
  logic                 second;

  logic                 ram_we;
  slot_entry_t          ram_wdata;
  slot_entry_t          ram_rdata;
  logic [ENTRY_W-1:0]   ram_rbits;

  unit_op_t             unit_op;
  logic [TIME_BITS-1:0] unit_a;
  logic [TIME_BITS-1:0] unit_sum;
  logic                 unit_lt;
  logic                 fire;
  logic [COIL_IDX_W-1:0] coil_bit;

  assign s_axis_tready = (state == ST_IDLE);
  // output register empty now or emptied at this edge
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  lrps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_idx),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rbits)
  );

  assign ram_rdata = slot_entry_t'(ram_rbits);

  always_comb begin
    ram_we             = (state == ST_TFILL) && !busy[scan_idx];
    ram_wdata.when     = second ? t_end : item_time;
    ram_wdata.relay    = item_relay;
    ram_wdata.set_coil = item_set;
    ram_wdata.level    = !second;
  end

  // one adder: end time of a pulse, or slot time against tick time
  always_comb begin
    unit_op = (state == ST_TICK) ? UNIT_OP_LT : UNIT_OP_ADD;
    unit_a  = (state == ST_TICK) ? ram_rdata.when : item_time;
  end

  lrps_unit u_unit (
    .op  (unit_op),
    .a   (unit_a),
    .b   ((state == ST_TICK) ? item_time : TIME_BITS'(hold_ticks)),
    .sum (unit_sum),
    .lt  (unit_lt)
  );

  assign fire     = (state == ST_TICK) && eval_vld && busy[eval_idx] && unit_lt;
  assign coil_bit = {ram_rdata.relay, !ram_rdata.set_coil};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= '0;
      free_cnt      <= CNT_W'(SLOTS);
      coil_drive    <= '0;
      m_axis_tvalid <= 1'b0;
      eval_vld      <= 1'b0;
      scan_done     <= 1'b0;
      second        <= 1'b0;
      acc           <= 1'b0;
      scan_idx      <= '0;
      eval_idx      <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_REPORT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            item_relay <= s_axis_tdata[1:0];
            item_set   <= s_axis_tdata[2];
            item_time  <= s_axis_tdata[34:3];
            scan_idx   <= '0;
            scan_done  <= 1'b0;
            eval_vld   <= 1'b0;
            second     <= 1'b0;
            acc        <= 1'b0;
            state      <= (s_axis_tuser == FUNC_TOGGLE) ? ST_TADD : ST_TICK;
          end
        end
        ST_TADD: begin
          t_end <= unit_sum;
          if (free_cnt < CNT_W'(MIN_FREE)) begin
            state <= ST_REPORT;
          end else begin
            acc   <= 1'b1;
            state <= ST_TFILL;
          end
        end
        ST_TFILL: begin
          if (!busy[scan_idx]) begin
            busy[scan_idx] <= 1'b1;
            free_cnt       <= free_cnt - 1'b1;
            second         <= 1'b1;
            if (second) begin
              state <= ST_REPORT;
            end
          end
          if (scan_idx != LAST) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_TICK: begin
          // read of slot scan_idx in flight while slot eval_idx is judged
          if (fire) begin
            busy[eval_idx] <= 1'b0;
            free_cnt       <= free_cnt + 1'b1;
            if (ram_rdata.relay < RELAY_W'(RELAYS)) begin
              coil_drive[coil_bit] <= ram_rdata.level;
            end
          end
          if (!scan_done) begin
            eval_vld <= 1'b1;
            eval_idx <= scan_idx;
            if (scan_idx == LAST) begin
              scan_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end else begin
            eval_vld <= 1'b0;
          end
          if (eval_vld && (eval_idx == LAST)) begin
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'd0, FREE_W'(free_cnt), coil_drive, acc};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LRPS_ASSERT_ALWAYS(a_free_count, clk, rst, free_cnt == CNT_W'(SLOTS - $countones(busy)))
  `LRPS_ASSERT_SAME(a_fill_free_slot, clk, rst, ram_we, (state == ST_TFILL) && acc)
  `LRPS_ASSERT_SAME(a_result_from_report, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_REPORT)
  `LRPS_ASSERT_NEXT(a_refused_keeps_table, clk, rst, (state == ST_TADD) && (free_cnt < CNT_W'(MIN_FREE)), $stable(busy))

endmodule

`default_nettype wire

[sim/lrps_checker.sv]
// scoreboard for the relay pulse scheduler: watches the config port and both stream channels,
// predicts every result from its own copy of the event table and compares field by field
// depends on lrps_pkg
`default_nettype none

module lrps_checker import lrps_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [HOLD_W-1:0] cfg_wr_data,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [39:0]       s_tdata,   // relay_index, set_coil, time_value
  input  wire logic              s_tuser,   // func
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [15:0]       m_tdata,   // accepted, coil_lines, free_slots
  input  wire logic              final_check,
  output int                     fail_count
);

  typedef struct packed {
    logic              accepted;
    logic [COIL_W-1:0] coils;
    logic [FREE_W-1:0] free_slots;
  } relay_result_t;

  logic [TIME_BITS-1:0] ev_when  [SLOTS];
  logic [RELAY_W-1:0]   ev_relay [SLOTS];
  logic                 ev_set   [SLOTS];
  logic                 ev_level [SLOTS];
  logic                 ev_busy  [SLOTS];
  logic [COIL_W-1:0]    coil_state;
  logic [HOLD_W-1:0]    hold_ticks;
  relay_result_t        pending_results [$];
  int                   mismatches = 0;
  bit                   drained = 1'b0;

  assign fail_count = mismatches;

  function automatic int free_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!ev_busy[i]) n++;
    return n;
  endfunction

  function automatic void book_event(input logic [RELAY_W-1:0] relay, input logic set,
                                     input logic level, input logic [TIME_BITS-1:0] when);
    bit done;
    done = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!done && !ev_busy[i]) begin
        ev_busy[i]  = 1'b1;
        ev_relay[i] = relay;
        ev_set[i]   = set;
        ev_level[i] = level;
        ev_when[i]  = when;
        done        = 1'b1;
      end
    end
  endfunction

  // relays beyond the last one still free their slots but drive no coil
  function automatic void fire_event(input int i);
    int bit_no;
    if (ev_relay[i] < RELAYS) begin
      bit_no = 2 * ev_relay[i] + (ev_set[i] ? 0 : 1);
      coil_state[bit_no] = ev_level[i];
    end
    ev_busy[i] = 1'b0;
  endfunction

  function automatic relay_result_t schedule_item(input logic func,
                                                  input logic [RELAY_W-1:0] relay,
                                                  input logic set,
                                                  input logic [TIME_BITS-1:0] t);
    relay_result_t r;
    r.accepted = 1'b0;
    if (func == FUNC_TOGGLE) begin
      if (free_count() >= MIN_FREE) begin
        book_event(relay, set, 1'b1, t);
        book_event(relay, set, 1'b0, t + TIME_BITS'(hold_ticks));
        r.accepted = 1'b1;
      end
    end else begin
      // plain unsigned compare, no wrap handling
      for (int i = 0; i < SLOTS; i++)
        if (ev_busy[i] && ev_when[i] < t) fire_event(i);
    end
    r.coils      = coil_state;
    r.free_slots = FREE_W'(free_count());
    return r;
  endfunction

  always @(posedge clk) begin : watch
    relay_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) ev_busy[i] = 1'b0;
      coil_state = '0;
      hold_ticks = HOLD_RESET;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) hold_ticks = cfg_wr_data;
      if (s_tvalid && s_tready)
        pending_results.push_back(schedule_item(s_tuser, s_tdata[1:0], s_tdata[2],
                                                s_tdata[34:3]));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing outstanding: tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[0] !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[6:1] !== want.coils) begin
            $error("coil_lines: expected %b, got %b", want.coils, m_tdata[6:1]);
            mismatches++;
          end
          if (m_tdata[10:7] !== want.free_slots) begin
            $error("free_slots: expected %0d, got %0d", want.free_slots, m_tdata[10:7]);
            mismatches++;
          end
          if (m_tdata[15:11] !== '0) begin
            $error("tdata padding: expected 0, got %b", m_tdata[15:11]);
            mismatches++;
          end
        end
      end
      if (final_check && !drained) begin
        drained = 1'b1;
        if (pending_results.size() != 0) begin
          $error("%0d results never arrived", pending_results.size());
          mismatches++;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sim/latching_relay_pulse_scheduler_top_tb.sv]
// testbench top for the relay pulse scheduler: clock, reset, bursty stream stimulus,
// a stalling result receiver, hold_ticks changes between phases and the verdict
// depends on lrps_pkg, lrps_checker and latching_relay_pulse_scheduler_top
`default_nettype none

module latching_relay_pulse_scheduler_top_tb;
  import lrps_pkg::*;

  localparam int SLOTS        = 8;
  localparam int DRAIN_CYCLES = SLOTS + 4;
  localparam int PHASE_ITEMS  = 130;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [HOLD_W-1:0] cfg_wr_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // relay_index, set_coil, time_value
  logic              s_axis_tuser = 1'b0; // func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // accepted, coil_lines, free_slots
  logic              end_check = 1'b0;
  int                fail_count;

  int                   items_sent   = 0;
  int                   results_seen = 0;
  int                   burst_left   = 0;
  bit                   offering     = 1'b0;
  int                   hold_now     = HOLD_RESET;
  logic [TIME_BITS-1:0] now_ticks;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  latching_relay_pulse_scheduler_top #(.SLOTS(SLOTS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lrps_checker #(.SLOTS(SLOTS)) i_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .final_check (end_check),
    .fail_count  (fail_count)
  );

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // receiver: rotating ready pattern, plus one long hold-off to back the block up
  initial begin : receiver
    int cyc, stall_left;
    bit held;
    cyc = 0;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) results_seen++;
      cyc++;
      if (!held && results_seen >= 250) begin
        held = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cyc / 64) % 3)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_item(input logic func, input logic [RELAY_W-1:0] relay,
                           input logic set, input logic [TIME_BITS-1:0] t);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, t, set, relay};
    offering = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_idle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hold_now = value;
  endtask

  // ticks marching forward with toggles just ahead of them, some noise
  task automatic random_phase(input int n_items);
    int span, pick;
    logic [RELAY_W-1:0] relay;
    span = hold_now + 8;
    if ($urandom_range(0, 3) == 0)
      now_ticks = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
    else
      now_ticks = $urandom();
    for (int k = 0; k < n_items; k++) begin
      pick  = $urandom_range(0, 99);
      relay = ($urandom_range(0, 7) == 0) ? 2'd3 : RELAY_W'($urandom_range(0, RELAYS - 1));
      if (pick < 45) begin
        send_item(FUNC_TOGGLE, relay, 1'($urandom_range(0, 1)),
                  now_ticks + $urandom_range(0, span / 2 + 4));
      end else if (pick < 92) begin
        now_ticks += $urandom_range(0, span / 3 + 2);
        send_item(FUNC_TICK, relay, 1'($urandom_range(0, 1)), now_ticks);
      end else if (pick < 99) begin
        send_item(1'($urandom_range(0, 1)), relay, 1'($urandom_range(0, 1)), $urandom());
      end else begin
        send_item(FUNC_TICK, relay, 1'($urandom_range(0, 1)), '1);
      end
    end
  endtask

  initial begin : stimulus
    burst_left = $urandom_range(1, 40);
    while (rst) @(posedge clk);

    // directed, hold_ticks at its reset value
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd0);
    send_item(FUNC_TOGGLE, 2'd0, 1'b1, 32'd100);
    send_item(FUNC_TOGGLE, 2'd1, 1'b0, 32'd100);
    // drop time wraps past zero
    send_item(FUNC_TOGGLE, 2'd2, 1'b1, 32'hFFFF_FFFE);
    // relay out of range
    send_item(FUNC_TOGGLE, 2'd3, 1'b1, 32'd50);
    // table full, then one slot free: both refused
    send_item(FUNC_TOGGLE, 2'd0, 1'b0, 32'd10);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd100);
    send_item(FUNC_TOGGLE, 2'd1, 1'b1, 32'd20);
    // equal time does not fire, one more does
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd100);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd101);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd399);
    send_item(FUNC_TOGGLE, 2'd2, 1'b0, 32'd200);
    send_item(FUNC_TICK,   2'd3, 1'b1, 32'hFFFF_FFFF);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd0);
    send_item(FUNC_TOGGLE, 2'd2, 1'b1, 32'd5);
    send_item(FUNC_TOGGLE, 2'd1, 1'b1, 32'd5);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd6);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd406);

    write_hold(16'd0);
    send_item(FUNC_TOGGLE, 2'd0, 1'b1, 32'd1000);
    send_item(FUNC_TICK,   2'd0, 1'b0, 32'd1001);
    random_phase(PHASE_ITEMS);
    write_hold(16'hFFFF);
    random_phase(PHASE_ITEMS);
    write_hold(HOLD_W'($urandom_range(1, 60)));
    random_phase(PHASE_ITEMS);
    write_hold(16'd1);
    random_phase(PHASE_ITEMS);
    write_hold(HOLD_W'($urandom_range(0, 65535)));
    random_phase(PHASE_ITEMS);
    write_hold(HOLD_RESET);
    random_phase(PHASE_ITEMS);

    wait_idle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
